/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the scaler address generator.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* sv/nnsa_pkg.sv */
// ----------------------------------------------------------------------------
// Scaler address package
// Widths, register indexes, shared types and the side clamp function.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nnsa_pkg;

	localparam int MAX_SIDE  = 4096;
	localparam int SIDE_W    = 13;
	localparam int COORD_W   = 12;
	localparam int INDEX_W   = 24;
	localparam int QUO_W     = COORD_W;
	localparam int NUM_CELLS = QUO_W;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_WIDTH  = 2'd0,
		REG_SOURCE_HEIGHT = 2'd1,
		REG_TARGET_WIDTH  = 2'd2,
		REG_TARGET_HEIGHT = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [SIDE_W-1:0] sw;
		logic [SIDE_W-1:0] sh;
		logic [SIDE_W-1:0] tw;
		logic [SIDE_W-1:0] th;
	} sides_t;

	typedef struct packed {
		logic [QUO_W-1:0] rem;
		logic [QUO_W-1:0] quo;
	} lane_t;

	typedef struct packed {
		lane_t              col;
		lane_t              row;
		logic [INDEX_W-1:0] dst_index;
		logic               in_range;
	} cell_data_t;

	// A zero side counts as one, a side above the maximum as the maximum.
	function automatic logic [SIDE_W-1:0] eff_side(logic [SIDE_W-1:0] v);
		logic [SIDE_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = SIDE_W'(1);
		end else if (v > SIDE_W'(MAX_SIDE)) begin
			r = SIDE_W'(MAX_SIDE);
		end
		return r;
	endfunction

endpackage

/* sv/nearest_neighbor_scale_address.sv */
// ----------------------------------------------------------------------------
// Nearest-neighbor scaling address generator
// Maps an output pixel coordinate to its source and destination pixel indices.
// ----------------------------------------------------------------------------
// The block takes one coordinate transfer in every clock cycle while the
// output is not stalled and returns each result through its registers in
// order: one front stage forms the products, a chain of 12 divider cells
// resolves one bit of the column and row quotients each, and one output stage
// forms the source index. The user must write the four size registers through
// the plain write port only while no transfer is in flight; the block itself
// does not enforce this. A size of zero acts as one and above 4096 as 4096.
`timescale 1ns / 1ps

module nearest_neighbor_scale_address import nnsa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [SIDE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [COORD_W-1:0]   out_col,
	input  logic [COORD_W-1:0]   out_row,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [INDEX_W-1:0]   src_index,
	output logic [INDEX_W-1:0]   dst_index,
	output logic                 in_range
);

	sides_t     sides_q;
	logic       in_ready;
	logic       valid_c [0:NUM_CELLS];
	logic       ready_c [0:NUM_CELLS];
	cell_data_t data_c  [0:NUM_CELLS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sides_q.sw <= SIDE_W'(640);
			sides_q.sh <= SIDE_W'(480);
			sides_q.tw <= SIDE_W'(640);
			sides_q.th <= SIDE_W'(480);
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SOURCE_WIDTH:  sides_q.sw <= eff_side(cfg_data);
				REG_SOURCE_HEIGHT: sides_q.sh <= eff_side(cfg_data);
				REG_TARGET_WIDTH:  sides_q.tw <= eff_side(cfg_data);
				REG_TARGET_HEIGHT: sides_q.th <= eff_side(cfg_data);
				default: ;
			endcase
		end
	end

	assign in_stall = !in_ready;

	nnsa_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.sides     (sides_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_col   (out_col),
		.out_row   (out_row),
		.nxt_valid (valid_c[0]),
		.nxt_ready (ready_c[0]),
		.nxt_data  (data_c[0])
	);

	for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
		nnsa_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.sides     (sides_q),
			.prv_valid (valid_c[k]),
			.prv_ready (ready_c[k]),
			.prv_data  (data_c[k]),
			.nxt_valid (valid_c[k+1]),
			.nxt_ready (ready_c[k+1]),
			.nxt_data  (data_c[k+1])
		);
	end

	nnsa_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.sides     (sides_q),
		.prv_valid (valid_c[NUM_CELLS]),
		.prv_ready (ready_c[NUM_CELLS]),
		.prv_data  (data_c[NUM_CELLS]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.src_index (src_index),
		.dst_index (dst_index),
		.in_range  (in_range)
	);

endmodule

/* sv/nnsa_front.sv */
// ----------------------------------------------------------------------------
// Scaler address front stage
// Forms the scaled dividends, the destination index and the range flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nnsa_front import nnsa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  sides_t             sides,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [COORD_W-1:0] out_col,
	input  logic [COORD_W-1:0] out_row,
	output logic               nxt_valid,
	input  logic               nxt_ready,
	output cell_data_t         nxt_data
);

	logic                     valid_q;
	cell_data_t               data_q;
	cell_data_t               data_d;
	logic [2*INDEX_W-1:0]     prod_col;
	logic [2*INDEX_W-1:0]     prod_row;
	logic [2*INDEX_W-1:0]     prod_dst;

	assign in_ready = !valid_q || nxt_ready;

	always_comb begin
		prod_col = 48'(out_col) * 48'(sides.sw);
		prod_row = 48'(out_row) * 48'(sides.sh);
		prod_dst = 48'(out_row) * 48'(sides.tw) + 48'(out_col);
		data_d.col.rem   = prod_col[INDEX_W-1:QUO_W];
		data_d.col.quo   = prod_col[QUO_W-1:0];
		data_d.row.rem   = prod_row[INDEX_W-1:QUO_W];
		data_d.row.quo   = prod_row[QUO_W-1:0];
		data_d.dst_index = prod_dst[INDEX_W-1:0];
		data_d.in_range  = (SIDE_W'(out_col) < sides.tw) && (SIDE_W'(out_row) < sides.th);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_q <= data_d;
		end
	end

	assign nxt_valid = valid_q;
	assign nxt_data  = data_q;

	`ASSERT_NXT(a_front_hold, clk, arst_n, valid_q && !nxt_ready, valid_q && $stable(data_q))

endmodule

/* sv/nnsa_cell.sv */
// ----------------------------------------------------------------------------
// Scaler divider cell
// Resolves one quotient bit of both the column and the row division.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nnsa_cell import nnsa_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  sides_t     sides,
	input  logic       prv_valid,
	output logic       prv_ready,
	input  cell_data_t prv_data,
	output logic       nxt_valid,
	input  logic       nxt_ready,
	output cell_data_t nxt_data
);

	logic       valid_q;
	cell_data_t data_q;
	cell_data_t data_d;

	function automatic lane_t div_step(lane_t a, logic [SIDE_W-1:0] d);
		logic [SIDE_W-1:0] t;
		logic              ge;
		lane_t             r;
		t  = {a.rem, a.quo[QUO_W-1]};
		ge = (t >= d);
		if (ge) begin
			t = t - d;
		end
		r.rem = t[QUO_W-1:0];
		r.quo = {a.quo[QUO_W-2:0], ge};
		return r;
	endfunction

	assign prv_ready = !valid_q || nxt_ready;

	always_comb begin
		data_d     = prv_data;
		data_d.col = div_step(prv_data.col, sides.tw);
		data_d.row = div_step(prv_data.row, sides.th);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (prv_ready) begin
			valid_q <= prv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prv_ready && prv_valid) begin
			data_q <= data_d;
		end
	end

	assign nxt_valid = valid_q;
	assign nxt_data  = data_q;

	`ASSERT_NXT(a_cell_hold, clk, arst_n, valid_q && !nxt_ready, valid_q && $stable(data_q))

endmodule

/* sv/nnsa_back.sv */
// ----------------------------------------------------------------------------
// Scaler address output stage
// Builds the source index from the quotients and holds the result transfer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nnsa_back import nnsa_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  sides_t             sides,
	input  logic               prv_valid,
	output logic               prv_ready,
	input  cell_data_t         prv_data,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [INDEX_W-1:0] src_index,
	output logic [INDEX_W-1:0] dst_index,
	output logic               in_range
);

	logic                 valid_q;
	logic [INDEX_W-1:0]   src_index_q;
	logic [INDEX_W-1:0]   dst_index_q;
	logic                 in_range_q;
	logic [2*INDEX_W-1:0] prod_src;

	assign prv_ready = !valid_q || !out_stall;

	always_comb begin
		prod_src = 48'(prv_data.row.quo) * 48'(sides.sw) + 48'(prv_data.col.quo);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (prv_ready) begin
			valid_q <= prv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (prv_ready && prv_valid) begin
			in_range_q <= prv_data.in_range;
			if (prv_data.in_range) begin
				src_index_q <= prod_src[INDEX_W-1:0];
				dst_index_q <= prv_data.dst_index;
			end else begin
				src_index_q <= '0;
				dst_index_q <= '0;
			end
		end
	end

	assign out_valid = valid_q;
	assign src_index = src_index_q;
	assign dst_index = dst_index_q;
	assign in_range  = in_range_q;

	`ASSERT_IMP(a_out_zero, clk, arst_n, valid_q && !in_range_q, (src_index_q == '0) && (dst_index_q == '0))

endmodule
